@@ sv/qalu_pkg.sv @@
`timescale 1ns / 1ps
package qalu_pkg;

  // component format
  localparam int CW = 32;
  localparam int FB = 16;

  // derived widths
  localparam int PW     = 2 * CW;         // one product
  localparam int HW     = 2 * CW + 2;     // signed sum of four products
  localparam int SW     = 2 * CW + 1;     // sum of four squares
  localparam int MW     = HW - 1;         // magnitude of a product sum
  localparam int DW     = MW - FB + 1;    // signed value before saturation
  localparam int NW     = MW + FB;        // scaled dividend
  localparam int NSTEP  = CW + 1;         // quotient and root digits
  localparam int RTW    = 2 * CW + 4;     // root trial width
  localparam int NFRONT = 3;
  localparam int NST    = NFRONT + NSTEP + 1;

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_NORM = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [DW-1:0] VMAX = {{(DW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {{(DW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

  typedef struct packed {
    logic [2:0]           req_type;
    logic signed [CW-1:0] a_real;
    logic signed [CW-1:0] a_i;
    logic signed [CW-1:0] a_j;
    logic signed [CW-1:0] a_k;
    logic signed [CW-1:0] b_real;
    logic signed [CW-1:0] b_i;
    logic signed [CW-1:0] b_j;
    logic signed [CW-1:0] b_k;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] res_real;
    logic signed [CW-1:0] res_i;
    logic signed [CW-1:0] res_j;
    logic signed [CW-1:0] res_k;
    logic [1:0]           status;
  } rsp_t;

  // one divider lane stage
  typedef struct packed {
    logic [SW-1:0]    rem;
    logic [NSTEP-1:0] lo;
    logic [NSTEP-1:0] q;
    logic [SW-1:0]    den;
    logic             neg;
    logic             ovf;
  } div_st_t;

  // one square root stage
  typedef struct packed {
    logic [SW-1:0]    rem;
    logic [NSTEP-1:0] root;
  } sq_st_t;

  // values that ride alongside the iterative stages
  typedef struct packed {
    logic [2:0]         op;
    logic [3:0][DW-1:0] direct;
    logic               dz;
  } side_t;

  typedef struct packed {
    logic [CW-1:0] val;
    logic          sat;
  } sat_t;

  // restoring division, one quotient digit
  function automatic div_st_t div_step(div_st_t s);
    div_st_t     r;
    logic [SW:0] t;
    r = s;
    t = {s.rem, s.lo[NSTEP-1]};
    if (t >= {1'b0, s.den}) begin
      r.rem = SW'(t - {1'b0, s.den});
      r.q   = {s.q[NSTEP-2:0], 1'b1};
    end else begin
      r.rem = t[SW-1:0];
      r.q   = {s.q[NSTEP-2:0], 1'b0};
    end
    r.lo = {s.lo[NSTEP-2:0], 1'b0};
    return r;
  endfunction

  // digit-by-digit square root, bit b of the root
  function automatic sq_st_t sqrt_step(sq_st_t s, int b);
    sq_st_t         r;
    logic [RTW-1:0] d;
    r = s;
    d = (RTW'(s.root) << (b + 1)) + (RTW'(1) << (2 * b));
    if (d <= RTW'(s.rem)) begin
      r.rem  = SW'(RTW'(s.rem) - d);
      r.root = s.root | (NSTEP'(1) << b);
    end
    return r;
  endfunction

  // clamp to the component range
  function automatic sat_t saturate(logic [DW-1:0] v);
    sat_t r;
    if ($signed(v) > $signed(VMAX)) begin
      r.val = VMAX[CW-1:0];
      r.sat = 1'b1;
    end else if ($signed(v) < $signed(VMIN)) begin
      r.val = VMIN[CW-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[CW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ sv/qalu_front.sv @@
`timescale 1ns / 1ps
module qalu_front (
  input  logic                           clk,
  input  logic [qalu_pkg::NFRONT-1:0]    en,
  input  qalu_pkg::req_t                 req,
  output qalu_pkg::side_t                side,
  output qalu_pkg::div_st_t [3:0]        lane_init,
  output qalu_pkg::sq_st_t               sq_init
);
  import qalu_pkg::*;

  function automatic logic signed [HW-1:0] sx(logic [PW-1:0] p);
    return {{(HW - PW){p[PW-1]}}, p};
  endfunction

  logic signed [CW-1:0] a [4];
  logic signed [CW-1:0] b [4];

  // stage 0 registers
  logic [2:0]    op0;
  logic [PW-1:0] prod0 [4][4];
  logic [PW-1:0] sq0 [4];
  logic [CW:0]   simp0 [4];

  // stage 1 registers
  logic [2:0]    op1;
  logic [HW-1:0] ham1 [4];
  logic [SW-1:0] ssq1;
  logic [CW:0]   simp1 [4];

  // stage 2 registers
  side_t         side2;
  div_st_t [3:0] lane2;
  sq_st_t        sq2;

  assign a[0] = req.a_real;
  assign a[1] = req.a_i;
  assign a[2] = req.a_j;
  assign a[3] = req.a_k;
  assign b[0] = req.b_real;
  assign b[1] = req.b_i;
  assign b[2] = req.b_j;
  assign b[3] = req.b_k;

  // products, squares and the short operations
  always_ff @(posedge clk) begin
    if (en[0]) begin
      op0 <= req.req_type;
      for (int i = 0; i < 4; i++) begin
        logic signed [PW-1:0] p;
        logic signed [CW-1:0] s;
        logic signed [CW:0]   ae;
        logic signed [CW:0]   be;
        for (int j = 0; j < 4; j++) begin
          p = a[i] * b[j];
          prod0[i][j] <= p;
        end
        s = (req.req_type == OP_NORM) ? a[i] : b[i];
        p = s * s;
        sq0[i] <= p;
        ae = {a[i][CW-1], a[i]};
        be = {b[i][CW-1], b[i]};
        case (req.req_type)
          OP_ADD:  simp0[i] <= ae + be;
          OP_SUB:  simp0[i] <= ae - be;
          OP_CONJ: simp0[i] <= (i == 0) ? ae : -ae;
          default: simp0[i] <= '0;
        endcase
      end
    end
  end

  // product sums for A*B or conj(B)*A, sum of squares
  always_ff @(posedge clk) begin
    if (en[1]) begin
      op1 <= op0;
      for (int i = 0; i < 4; i++) simp1[i] <= simp0[i];
      ssq1 <= SW'(sq0[0]) + SW'(sq0[1]) + SW'(sq0[2]) + SW'(sq0[3]);
      if (op0 == OP_DIV) begin
        ham1[0] <= sx(prod0[0][0]) + sx(prod0[1][1]) + sx(prod0[2][2]) + sx(prod0[3][3]);
        ham1[1] <= sx(prod0[1][0]) - sx(prod0[0][1]) - sx(prod0[3][2]) + sx(prod0[2][3]);
        ham1[2] <= sx(prod0[2][0]) + sx(prod0[3][1]) - sx(prod0[0][2]) - sx(prod0[1][3]);
        ham1[3] <= sx(prod0[3][0]) - sx(prod0[2][1]) + sx(prod0[1][2]) - sx(prod0[0][3]);
      end else begin
        ham1[0] <= sx(prod0[0][0]) - sx(prod0[1][1]) - sx(prod0[2][2]) - sx(prod0[3][3]);
        ham1[1] <= sx(prod0[0][1]) + sx(prod0[1][0]) + sx(prod0[2][3]) - sx(prod0[3][2]);
        ham1[2] <= sx(prod0[0][2]) - sx(prod0[1][3]) + sx(prod0[2][0]) + sx(prod0[3][1]);
        ham1[3] <= sx(prod0[0][3]) + sx(prod0[1][2]) - sx(prod0[2][1]) + sx(prod0[3][0]);
      end
    end
  end

  // magnitudes, product scaling, dividend setup
  always_ff @(posedge clk) begin
    if (en[2]) begin
      side2.op <= op1;
      side2.dz <= (op1 == OP_DIV) && (ssq1 == '0);
      sq2.rem  <= ssq1;
      sq2.root <= '0;
      for (int i = 0; i < 4; i++) begin
        logic          neg;
        logic [HW-1:0] absv;
        logic [MW-1:0] mag;
        logic [DW-1:0] shv;
        logic [NW-1:0] n;
        logic [SW-1:0] hi;
        neg  = ham1[i][HW-1];
        absv = neg ? -ham1[i] : ham1[i];
        mag  = absv[MW-1:0];
        shv  = DW'(mag >> FB);
        n    = {mag, {FB{1'b0}}};
        hi   = SW'(n >> NSTEP);
        if (op1 == OP_MUL) begin
          side2.direct[i] <= neg ? -shv : shv;
        end else begin
          side2.direct[i] <= {{(DW - CW - 1){simp1[i][CW]}}, simp1[i]};
        end
        lane2[i].rem <= hi;
        lane2[i].lo  <= n[NSTEP-1:0];
        lane2[i].q   <= '0;
        lane2[i].den <= ssq1;
        lane2[i].neg <= neg;
        lane2[i].ovf <= hi >= ssq1;
      end
    end
  end

  assign side      = side2;
  assign lane_init = lane2;
  assign sq_init   = sq2;

endmodule

@@ sv/qalu_div.sv @@
`timescale 1ns / 1ps
module qalu_div (
  input  logic                         clk,
  input  logic [qalu_pkg::NSTEP-1:0]   en,
  input  qalu_pkg::div_st_t            init,
  output qalu_pkg::div_st_t            result
);
  import qalu_pkg::*;

  div_st_t st [NSTEP];

  // one quotient digit per stage
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[k]) st[k] <= div_step(init);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[k]) st[k] <= div_step(st[k-1]);
      end
    end
  end

  assign result = st[NSTEP-1];

endmodule

@@ sv/qalu_sqrt.sv @@
`timescale 1ns / 1ps
module qalu_sqrt (
  input  logic                         clk,
  input  logic [qalu_pkg::NSTEP-1:0]   en,
  input  qalu_pkg::sq_st_t             init,
  output qalu_pkg::sq_st_t             result
);
  import qalu_pkg::*;

  sq_st_t st [NSTEP];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[k]) st[k] <= sqrt_step(init, NSTEP - 1 - k);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[k]) st[k] <= sqrt_step(st[k-1], NSTEP - 1 - k);
      end
    end
  end

  assign result = st[NSTEP-1];

endmodule

@@ sv/quaternion_alu_top.sv @@
`timescale 1ns / 1ps
// Quaternion arithmetic unit on signed Q16.16 components: add, subtract,
// Hamilton product, division conj(B)*A/|B|^2, conjugate and norm of A.
// Every request passes the same 37-stage pipeline (three front stages for
// products and sums, 33 stages of one quotient digit or one root bit each,
// one output register). One request can enter every cycle unless
// req_stall is raised. A stall on the result side holds only the stages
// behind it that are full; empty stages keep accepting.
// Overflow saturates with status 2, a zero divisor gives zero results with
// status 1.
module quaternion_alu_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  qalu_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output qalu_pkg::rsp_t  rsp
);
  import qalu_pkg::*;

  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  side_t         front_side;
  div_st_t [3:0] lane_init;
  div_st_t [3:0] lane_out;
  sq_st_t        sq_init;
  sq_st_t        sq_out;
  side_t         side [NSTEP];
  rsp_t          rsp_next;

  // a stage loads when it is empty or the one after it moves
  always_comb begin
    rdy[NST-1] = !vld[NST-1] || !rsp_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign req_stall = !rdy[0];
  assign rsp_valid = vld[NST-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= req_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  qalu_front u_front (
    .clk       (clk),
    .en        (rdy[NFRONT-1:0]),
    .req       (req),
    .side      (front_side),
    .lane_init (lane_init),
    .sq_init   (sq_init)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qalu_div u_div (
      .clk    (clk),
      .en     (rdy[NFRONT+NSTEP-1:NFRONT]),
      .init   (lane_init[i]),
      .result (lane_out[i])
    );
  end

  qalu_sqrt u_sqrt (
    .clk    (clk),
    .en     (rdy[NFRONT+NSTEP-1:NFRONT]),
    .init   (sq_init),
    .result (sq_out)
  );

  // side values delayed to match the iterative stages
  for (genvar k = 0; k < NSTEP; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rdy[NFRONT+k]) side[k] <= front_side;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rdy[NFRONT+k]) side[k] <= side[k-1];
      end
    end
  end

  // result selection, saturation and status
  always_comb begin
    side_t         sd;
    logic [DW-1:0] v;
    logic [DW-1:0] qv;
    sat_t          s;
    logic [CW-1:0] res [4];
    logic          any_sat;
    sd      = side[NSTEP-1];
    any_sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      qv = DW'(lane_out[i].q);
      case (sd.op) inside
        OP_ADD, OP_SUB, OP_MUL, OP_CONJ: v = sd.direct[i];
        OP_DIV:  v = lane_out[i].neg ? -qv : qv;
        OP_NORM: v = (i == 0) ? DW'(sq_out.root) : '0;
        default: v = '0;
      endcase
      s = saturate(v);
      if (sd.op == OP_DIV && lane_out[i].ovf) begin
        s.val = lane_out[i].neg ? VMIN[CW-1:0] : VMAX[CW-1:0];
        s.sat = 1'b1;
      end
      res[i]  = s.val;
      any_sat = any_sat | s.sat;
    end
    if (sd.dz) begin
      rsp_next = '0;
      rsp_next.status = ST_DZ;
    end else begin
      rsp_next.res_real = res[0];
      rsp_next.res_i    = res[1];
      rsp_next.res_j    = res[2];
      rsp_next.res_k    = res[3];
      rsp_next.status   = any_sat ? ST_SAT : ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy[NST-1]) rsp <= rsp_next;
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import qalu_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int WATCH_LIMIT = 20000;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW - 1){1'b0}}};

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  rsp_t expected_rsp_q[$];
  int   err_cnt;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   quiet_cycles;

  quaternion_alu_top DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hamilton product p*q on exact wide values
  function automatic void hamilton(input wide_t p[4], input wide_t q[4], output wide_t o[4]);
    o[0] = p[0] * q[0] - p[1] * q[1] - p[2] * q[2] - p[3] * q[3];
    o[1] = p[0] * q[1] + p[1] * q[0] + p[2] * q[3] - p[3] * q[2];
    o[2] = p[0] * q[2] - p[1] * q[3] + p[2] * q[0] + p[3] * q[1];
    o[3] = p[0] * q[3] + p[1] * q[2] - p[2] * q[1] + p[3] * q[0];
  endfunction

  // floor square root of a non-negative value
  function automatic wide_t floor_sqrt(wide_t s);
    wide_t root;
    wide_t trial;
    root = '0;
    for (int b = CW; b >= 0; b--) begin
      trial = root | (wide_t'(1) <<< b);
      if (trial * trial <= s) root = trial;
    end
    return root;
  endfunction

  // expected quaternion result for one request
  function automatic rsp_t quat_result(req_t r);
    wide_t a[4];
    wide_t b[4];
    wide_t cb[4];
    wide_t v[4];
    wide_t den;
    logic  sat;
    logic  dz;
    logic signed [CW-1:0] f[4];
    rsp_t  o;
    a[0] = r.a_real; a[1] = r.a_i; a[2] = r.a_j; a[3] = r.a_k;
    b[0] = r.b_real; b[1] = r.b_i; b[2] = r.b_j; b[3] = r.b_k;
    for (int i = 0; i < 4; i++) v[i] = '0;
    sat = 1'b0;
    dz  = 1'b0;
    case (r.req_type)
      OP_ADD: for (int i = 0; i < 4; i++) v[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 4; i++) v[i] = a[i] - b[i];
      OP_MUL: begin
        hamilton(a, b, v);
        for (int i = 0; i < 4; i++) v[i] = v[i] / (wide_t'(1) <<< FB);
      end
      OP_DIV: begin
        den = b[0] * b[0] + b[1] * b[1] + b[2] * b[2] + b[3] * b[3];
        if (den == 0) begin
          dz = 1'b1;
        end else begin
          cb[0] = b[0];
          for (int i = 1; i < 4; i++) cb[i] = -b[i];
          hamilton(cb, a, v);
          for (int i = 0; i < 4; i++) v[i] = (v[i] <<< FB) / den;
        end
      end
      OP_CONJ: begin
        v[0] = a[0];
        for (int i = 1; i < 4; i++) v[i] = -a[i];
      end
      OP_NORM: v[0] = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
      default: ;
    endcase
    // clamp to the component range
    for (int i = 0; i < 4; i++) begin
      if (v[i] > wide_t'(CMAX)) begin
        f[i] = CMAX;
        sat = 1'b1;
      end else if (v[i] < wide_t'(CMIN)) begin
        f[i] = CMIN;
        sat = 1'b1;
      end else begin
        f[i] = v[i][CW-1:0];
      end
    end
    o.res_real = f[0];
    o.res_i    = f[1];
    o.res_j    = f[2];
    o.res_k    = f[3];
    o.status   = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
    return o;
  endfunction

  // send one transaction and record its expected result
  task automatic send_req(req_t r);
    if ($urandom_range(99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsp_q.push_back(quat_result(r));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // random component biased toward interesting magnitudes
  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      2: case ($urandom_range(4))
        0: return CMAX;
        1: return CMIN;
        2: return '0;
        3: return 32'sd1;
        default: return -32'sd1;
      endcase
      3: return $signed($urandom) >>> $urandom_range(31);
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic signed [CW-1:0] ar,
      logic signed [CW-1:0] ai, logic signed [CW-1:0] aj, logic signed [CW-1:0] ak,
      logic signed [CW-1:0] br, logic signed [CW-1:0] bi, logic signed [CW-1:0] bj,
      logic signed [CW-1:0] bk);
    req_t r;
    r.req_type = op;
    r.a_real = ar; r.a_i = ai; r.a_j = aj; r.a_k = ak;
    r.b_real = br; r.b_i = bi; r.b_j = bj; r.b_k = bk;
    return r;
  endfunction

  // extremes, every opcode and the special cases
  task automatic test_directed();
    send_req(make_req(OP_ADD, 32'sh0001_0000, 2, 3, 4, 32'sh0001_0000, 5, 6, 7));
    send_req(make_req(OP_ADD, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1, -1));
    send_req(make_req(OP_SUB, CMIN, CMAX, 0, -1, CMAX, CMIN, CMIN, CMAX));
    send_req(make_req(OP_SUB, 5, -5, 7, -7, 5, -5, 7, -7));
    send_req(make_req(OP_MUL, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_8000, 1,
                      32'sh0000_8000, -32'sh0004_0000, 32'sh0001_0000, -1));
    send_req(make_req(OP_MUL, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_req(make_req(OP_MUL, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX));
    send_req(make_req(OP_DIV, 32'sh0003_0000, 1, -2, 3, 32'sh0001_0000, 0, 0, 0));
    send_req(make_req(OP_DIV, CMAX, CMAX, CMAX, CMAX, 1, 0, 0, 0));
    send_req(make_req(OP_DIV, 5, 6, 7, 8, 0, 0, 0, 0));
    send_req(make_req(OP_DIV, CMIN, 3, CMAX, -9, CMIN, CMIN, CMIN, CMIN));
    send_req(make_req(OP_CONJ, CMAX, CMIN, CMAX, -1, 0, 0, 0, 0));
    send_req(make_req(OP_CONJ, CMIN, 1, 0, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_req(make_req(OP_NORM, CMIN, CMIN, CMIN, CMIN, 0, 0, 0, 0));
    send_req(make_req(OP_NORM, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 1, 1, 1, 1));
    send_req(make_req(OP_NORM, 0, 0, 0, 0, CMIN, CMAX, 0, 0));
    send_req(make_req(OP_NORM, 0, 1, 0, 0, 0, 0, 0, 0));
    send_req(make_req(3'd6, CMAX, CMIN, 1, 2, 3, 4, 5, 6));
    send_req(make_req(3'd7, -1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  // random requests, mostly defined opcodes
  task automatic test_random(int count);
    req_t r;
    for (int n = 0; n < count; n++) begin
      r = make_req($urandom_range(99) < 4 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5)),
                   rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), rand_comp());
      if (r.req_type == OP_DIV && $urandom_range(19) == 0) begin
        r.b_real = '0; r.b_i = '0; r.b_j = '0; r.b_k = '0;
      end
      send_req(r);
    end
  endtask

  // check each accepted result and randomize result-side stall
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result transaction with nothing expected");
          err_cnt++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp.res_real !== exp_rsp.res_real) begin
            $error("res_real expected %0d actual %0d", exp_rsp.res_real, rsp.res_real);
            err_cnt++;
          end
          if (rsp.res_i !== exp_rsp.res_i) begin
            $error("res_i expected %0d actual %0d", exp_rsp.res_i, rsp.res_i);
            err_cnt++;
          end
          if (rsp.res_j !== exp_rsp.res_j) begin
            $error("res_j expected %0d actual %0d", exp_rsp.res_j, rsp.res_j);
            err_cnt++;
          end
          if (rsp.res_k !== exp_rsp.res_k) begin
            $error("res_k expected %0d actual %0d", exp_rsp.res_k, rsp.res_k);
            err_cnt++;
          end
          if (rsp.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, rsp.status);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("quaternion_alu_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    snd_idle_pct = 14;
    rcv_idle_pct = 58;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    wait_drained();
    snd_idle_pct = 58;
    rcv_idle_pct = 14;
    test_random(440);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(440);
    wait_drained();
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("quaternion_alu_top regression: pass");
    end else begin
      $display("quaternion_alu_top regression: fail");
    end
    $finish;
  end

endmodule
